### rtl/vsp_pkg.sv
`default_nettype none

package vsp_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned TABLE_DEPTH = 1 << ADDR_W;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned SPEED_W     = 20;
  localparam int unsigned POS_W       = 34;
  localparam int unsigned IPART_W     = POS_W - FRAC_BITS;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = LEN_W;
  localparam int unsigned PROD_W      = FRAC_BITS + SAMPLE_W + 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_WRAP   = 2'd1,
    CFG_START  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_INTERP  = 2'd1,
    CMD_REPEAT  = 2'd2,
    CMD_SILENCE = 2'd3
  } cmd_kind_e;

  // one classified request handed from front to back
  typedef struct packed {
    cmd_kind_e             kind;
    logic [ADDR_W-1:0]     addr0;
    logic [ADDR_W-1:0]     addr1;
    logic                  v0;
    logic                  v1;
    logic [FRAC_BITS-1:0]  frac;
    logic [SAMPLE_W-1:0]   wdata;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/vsp_front.sv
`default_nettype none

module vsp_front import vsp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        q_full_i,
  input  logic [OPCODE_W-1:0]         opcode_i,
  input  logic [ADDR_W-1:0]           table_address_i,
  input  logic signed [SAMPLE_W-1:0]  table_sample_i,
  input  logic signed [SPEED_W-1:0]   speed_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  output cmd_t                        cmd_o,
  output logic                        cmd_push_o
);

  localparam logic [LEN_W-1:0] LenMax = LEN_W'(TABLE_DEPTH);

  logic [LEN_W-1:0]           len_q;
  logic                       wrap_q;
  logic [ADDR_W-1:0]          start_q;
  logic [LEN_W-1:0]           len_sat;
  logic signed [POS_W-1:0]    pos_q, pos_d;
  logic signed [POS_W-1:0]    speed_ext, len_fx, start_fx;
  logic signed [IPART_W-1:0]  ipart, ipart1;
  logic                       fwd, active, accept;

  // length saturates to 1 .. table depth
  always_comb begin
    if (cfg_data_i == '0) begin
      len_sat = LEN_W'(1);
    end else if (cfg_data_i > LenMax) begin
      len_sat = LenMax;
    end else begin
      len_sat = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenMax;
      wrap_q  <= 1'b0;
      start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LENGTH: len_q   <= len_sat;
        CFG_WRAP:   wrap_q  <= cfg_data_i[0];
        CFG_START:  start_q <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = push_i && !q_full_i;
  assign speed_ext = {{(POS_W-SPEED_W){speed_i[SPEED_W-1]}}, speed_i};
  assign len_fx    = {{(POS_W-LEN_W-FRAC_BITS){1'b0}}, len_q, {FRAC_BITS{1'b0}}};
  assign start_fx  = {{(POS_W-ADDR_W-FRAC_BITS){1'b0}}, start_q, {FRAC_BITS{1'b0}}};
  assign fwd       = !speed_i[SPEED_W-1];
  assign active    = fwd ? (pos_q < len_fx) : (pos_q > $signed(POS_W'(0)));
  assign ipart     = pos_q[POS_W-1:FRAC_BITS];
  assign ipart1    = ipart + $signed(IPART_W'(1));

  always_comb begin
    pos_d      = pos_q;
    cmd_push_o = 1'b0;
    cmd_o.kind  = CMD_SILENCE;
    cmd_o.addr0 = ipart[ADDR_W-1:0];
    cmd_o.addr1 = ipart1[ADDR_W-1:0];
    cmd_o.v0    = !ipart[IPART_W-1] && (ipart[IPART_W-2:0] < len_q);
    cmd_o.v1    = !ipart1[IPART_W-1] && (ipart1[IPART_W-2:0] < len_q);
    cmd_o.frac  = pos_q[FRAC_BITS-1:0];
    cmd_o.wdata = table_sample_i;
    if (accept) begin
      unique case (opcode_e'(opcode_i))
        OP_WRITE: begin
          cmd_push_o  = 1'b1;
          cmd_o.kind  = CMD_WRITE;
          cmd_o.addr0 = table_address_i;
        end
        OP_RESTART: begin
          pos_d = start_fx;
        end
        OP_TICK: begin
          cmd_push_o = 1'b1;
          if (active) begin
            cmd_o.kind = CMD_INTERP;
            pos_d      = pos_q + speed_ext;
          end else if (wrap_q) begin
            cmd_o.kind = CMD_REPEAT;
            pos_d      = fwd ? '0 : len_fx;
          end else begin
            cmd_o.kind = CMD_SILENCE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

### rtl/vsp_cmd_queue.sv
`default_nettype none

module vsp_cmd_queue import vsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vsp_back.sv
`default_nettype none

module vsp_back import vsp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  input  logic                        pop,
  output logic                        empty,
  output logic signed [SAMPLE_W-1:0]  out_sample_o
);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned PtrW     = $clog2(OutDepth);
  localparam int unsigned CntW     = $clog2(OutDepth + 1);

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  logic                      credit_ok, issue_tick;
  logic [CntW:0]             occupancy;

  // stage a: table read
  logic                      a_valid_q;
  cmd_kind_e                 a_kind_q;
  logic                      a_v0_q, a_v1_q;
  logic [FRAC_BITS-1:0]      a_frac_q;
  logic [SAMPLE_W-1:0]       rd0_q, rd1_q;

  // stage b: multiply
  logic signed [SAMPLE_W-1:0] s0, s1;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic                       b_valid_q;
  cmd_kind_e                  b_kind_q;
  logic signed [SAMPLE_W-1:0] b_s0_q;
  logic signed [PROD_W-1:0]   b_prod_q;

  // stage c: finish and queue
  logic signed [PROD_W-FRAC_BITS-1:0] step;
  logic signed [SAMPLE_W-1:0]         interp, result;
  logic signed [SAMPLE_W-1:0]         last_q;
  logic [SAMPLE_W-1:0]                out_mem_q [OutDepth];
  logic [PtrW-1:0]                    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                    out_cnt_q;
  logic                               out_pop;

  // a tick enters only if a result slot is free for it, counting ticks still in flight
  assign occupancy  = (CntW+1)'(out_cnt_q) + (CntW+1)'(a_valid_q) + (CntW+1)'(b_valid_q);
  assign credit_ok  = occupancy < (CntW+1)'(OutDepth);
  assign cmd_pop_o  = cmd_valid_i && ((cmd_i.kind == CMD_WRITE) || credit_ok);
  assign issue_tick = cmd_pop_o && (cmd_i.kind != CMD_WRITE);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.kind == CMD_WRITE)) begin
      mem[cmd_i.addr0] <= cmd_i.wdata;
    end
    rd0_q <= mem[cmd_i.addr0];
    rd1_q <= mem[cmd_i.addr1];
  end

  always_ff @(posedge clk_i) begin
    a_kind_q <= cmd_i.kind;
    a_v0_q   <= cmd_i.v0;
    a_v1_q   <= cmd_i.v1;
    a_frac_q <= cmd_i.frac;
  end

  assign s0   = a_v0_q ? $signed(rd0_q) : '0;
  assign s1   = a_v1_q ? $signed(rd1_q) : '0;
  assign diff = {s1[SAMPLE_W-1], s1} - {s0[SAMPLE_W-1], s0};
  assign prod = $signed({1'b0, a_frac_q}) * diff;

  always_ff @(posedge clk_i) begin
    b_kind_q <= a_kind_q;
    b_s0_q   <= s0;
    b_prod_q <= prod;
  end

  // floor of the scaled product, result stays between the two neighbors
  assign step   = b_prod_q[PROD_W-1:FRAC_BITS];
  assign interp = b_s0_q + step[SAMPLE_W-1:0];

  always_comb begin
    case (b_kind_q)
      CMD_INTERP: result = interp;
      CMD_REPEAT: result = last_q;
      default:    result = '0;
    endcase
  end

  assign empty        = (out_cnt_q == '0);
  assign out_pop      = pop && !empty;
  assign out_sample_o = out_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      out_mem_q[wr_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      last_q    <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      a_valid_q <= issue_tick;
      b_valid_q <= a_valid_q;
      if (b_valid_q) begin
        last_q   <= result;
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (b_valid_q && !out_pop) begin
        out_cnt_q <= out_cnt_q + CntW'(1);
      end else if (out_pop && !b_valid_q) begin
        out_cnt_q <= out_cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (out_cnt_q != CntW'(OutDepth)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> $past(a_valid_q))
    else $error("stage b valid without stage a");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_kind_q != CMD_WRITE))
    else $error("table write entered the tick pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

### rtl/varispeed_sample_playback_unit.sv
// path: a tick passes the command queue, the stage a table read, the stage b multiply and the result queue
// throughput: one request per cycle while full is low; table writes, ticks and restarts mix freely
// the dual-read table memory plus one multiplier set the per-tick pipeline depth
// reset: length 65536, wrap off, start 0, position 0, last output 0, queues empty
// reset does not clear the sample table; entries read undefined until written
`default_nettype none

module varispeed_sample_playback_unit import vsp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [OPCODE_W-1:0]         opcode_i,
  input  logic [ADDR_W-1:0]           table_address_i,
  input  logic signed [SAMPLE_W-1:0]  table_sample_i,
  input  logic signed [SPEED_W-1:0]   speed_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SAMPLE_W-1:0]  out_sample_o,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  cmd_t front_cmd, back_cmd;
  logic front_push, back_pop, cmdq_empty;

  // front: config registers, play position, end-of-table classification
  vsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .q_full_i        (full),
    .opcode_i        (opcode_i),
    .table_address_i (table_address_i),
    .table_sample_i  (table_sample_i),
    .speed_i         (speed_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_o           (front_cmd),
    .cmd_push_o      (front_push)
  );

  // short command queue so front and back stall independently;
  // its full flag is the request-side full
  vsp_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (back_pop),
    .data_o  (back_cmd),
    .empty_o (cmdq_empty)
  );

  // back: table memory, interpolation pipeline, last output, result queue
  vsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (back_cmd),
    .cmd_valid_i  (!cmdq_empty),
    .cmd_pop_o    (back_pop),
    .pop          (pop),
    .empty        (empty),
    .out_sample_o (out_sample_o)
  );

endmodule

`default_nettype wire
